@@ rtl/rald_pkg.sv @@
`timescale 1ns / 1ps

package rald_pkg;

  localparam int ADDRESS_BYTES = 6;
  localparam int BYTE_W        = 8;
  localparam int ADDR_W        = BYTE_W * ADDRESS_BYTES;
  localparam int OUT_ADDR_W    = 48;
  localparam int LEN_W         = 7;
  localparam int RELAY_W       = 4;
  localparam int GRP_W         = RELAY_W + 1;
  localparam int CNT_W         = $clog2(ADDRESS_BYTES + 1);
  localparam int S_TDATA_W     = 16;
  localparam int M_TDATA_W     = 56;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               list_start;
    logic [RELAY_W-1:0] relay_count;
  } item_t;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] address;
    logic                  address_is_last;
    logic [LEN_W-1:0]      list_length;
    logic                  group_error;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t result;
  } step_result_t;

endpackage

@@ rtl/relay_address_list_decompressor.sv @@
`timescale 1ns / 1ps
// Compressed relay address list decoder.
// Input stream: one list byte per transfer. tdata[7:0] is data_byte,
// tdata[11:8] relay_count (read on the first byte of a list), tuser is
// list_start and restarts decoding, also in mid list.
// Output stream: one decoded address per transfer. tdata[47:0] is the
// address (list byte zero most significant), tdata[54:48] the consumed
// length on the last address, tlast marks the last address of the list,
// tuser flags an overlong group (address zero, list aborted).
// Bytes that produce no address are consumed silently; bytes outside an
// active list are ignored.
// Throughput: one byte per clock unless the receiver stalls. A byte is
// held in the input register, decoded combinationally with the address and
// group registers, and its address is loaded into the output register.
// Reset clears the list state; the block then waits for list_start.
// When the receiver stalls, the held address stays on the output, one more
// byte waits in the input register, and tready then drops.
module relay_address_list_decompressor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rald_pkg::S_TDATA_W-1:0] s_axis_tdata,  // data_byte, relay_count
  input  logic                           s_axis_tuser,  // list_start
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rald_pkg::M_TDATA_W-1:0] m_axis_tdata,  // address, list_length
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser   // group_error
);
  import rald_pkg::*;

  item_t        item;
  logic         item_valid;
  logic         load_ok;
  logic         advance;
  step_result_t res;

  assign advance = item_valid && load_ok;

  rald_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  rald_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .res  (res)
  );

  rald_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .res           (res),
    .load_ok       (load_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  a_output_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(advance))
    else $error("output loaded without a byte being processed");

endmodule

@@ rtl/rald_in_reg.sv @@
`timescale 1ns / 1ps

module rald_in_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rald_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          advance,
  output logic                          item_valid,
  output rald_pkg::item_t               item
);
  import rald_pkg::*;

  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item.data_byte   <= s_axis_tdata[BYTE_W-1:0];
      item.relay_count <= s_axis_tdata[BYTE_W +: RELAY_W];
      item.list_start  <= s_axis_tuser;
    end
  end

endmodule

@@ rtl/rald_core.sv @@
`timescale 1ns / 1ps

module rald_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  rald_pkg::item_t        item,
  output rald_pkg::step_result_t res
);
  import rald_pkg::*;

  logic [ADDR_W-1:0] prev_addr, prev_addr_next, base_prev;
  logic [ADDR_W-1:0] group_sr, group_sr_next, base_group, delta;
  logic [CNT_W-1:0]  group_fill, group_fill_next, base_fill;
  logic [CNT_W-1:0]  header_seen, header_seen_next, base_header;
  logic [GRP_W-1:0]  groups_left, groups_left_next, base_groups, groups_dec;
  logic [LEN_W-1:0]  consumed, consumed_next, base_consumed;
  logic              list_active, list_active_next;

  always_comb begin
    if (item.list_start) begin
      base_prev     = '0;
      base_group    = '0;
      base_fill     = '0;
      base_header   = '0;
      base_groups   = {1'b0, item.relay_count} + GRP_W'(1);
      base_consumed = '0;
    end else begin
      base_prev     = prev_addr;
      base_group    = group_sr;
      base_fill     = group_fill;
      base_header   = header_seen;
      base_groups   = groups_left;
      base_consumed = consumed;
    end
    delta      = {base_group[ADDR_W-BYTE_W-1:0], 1'b0, item.data_byte[BYTE_W-1:1]};
    groups_dec = (base_groups != '0) ? base_groups - GRP_W'(1) : base_groups;
  end

  always_comb begin
    prev_addr_next   = prev_addr;
    group_sr_next    = group_sr;
    group_fill_next  = group_fill;
    header_seen_next = header_seen;
    groups_left_next = groups_left;
    consumed_next    = consumed;
    list_active_next = list_active;
    res              = '0;
    if (item.list_start || list_active) begin
      prev_addr_next   = base_prev;
      group_sr_next    = base_group;
      group_fill_next  = base_fill;
      header_seen_next = base_header;
      groups_left_next = base_groups;
      consumed_next    = base_consumed + LEN_W'(1);
      list_active_next = 1'b1;
      if (base_header < CNT_W'(ADDRESS_BYTES)) begin
        prev_addr_next   = {base_prev[ADDR_W-BYTE_W-1:0], item.data_byte};
        header_seen_next = base_header + CNT_W'(1);
        if (base_header == CNT_W'(ADDRESS_BYTES - 1)) begin
          res.valid          = 1'b1;
          res.result.address = OUT_ADDR_W'(prev_addr_next);
        end
      end else if (base_fill >= CNT_W'(ADDRESS_BYTES)) begin
        group_fill_next        = '0;
        group_sr_next          = '0;
        list_active_next       = 1'b0;
        res.valid              = 1'b1;
        res.result.group_error = 1'b1;
      end else if (!item.data_byte[0]) begin
        group_sr_next   = delta;
        group_fill_next = base_fill + CNT_W'(1);
      end else begin
        prev_addr_next     = base_prev ^ delta;
        group_sr_next      = '0;
        group_fill_next    = '0;
        groups_left_next   = groups_dec;
        res.valid          = 1'b1;
        res.result.address = OUT_ADDR_W'(prev_addr_next);
        if (groups_dec == '0) begin
          list_active_next           = 1'b0;
          res.result.address_is_last = 1'b1;
          res.result.list_length     = consumed_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_addr   <= '0;
      group_sr    <= '0;
      group_fill  <= '0;
      header_seen <= '0;
      groups_left <= '0;
      consumed    <= '0;
      list_active <= 1'b0;
    end else if (step) begin
      prev_addr   <= prev_addr_next;
      group_sr    <= group_sr_next;
      group_fill  <= group_fill_next;
      header_seen <= header_seen_next;
      groups_left <= groups_left_next;
      consumed    <= consumed_next;
      list_active <= list_active_next;
    end
  end

  a_last_ends_list: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && res.result.address_is_last |=> !list_active)
    else $error("list still active after its last address");

  a_error_ends_list: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && res.result.group_error |=> !list_active)
    else $error("list still active after an overlong group");

  a_no_group_in_header: assert property (@(posedge clk) disable iff (rst)
    header_seen < CNT_W'(ADDRESS_BYTES) |-> group_fill == '0 && group_sr == '0)
    else $error("group bytes held before the base address is complete");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    header_seen <= CNT_W'(ADDRESS_BYTES) && group_fill <= CNT_W'(ADDRESS_BYTES))
    else $error("header or group count out of range");

endmodule

@@ rtl/rald_out_reg.sv @@
`timescale 1ns / 1ps

module rald_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  rald_pkg::step_result_t        res,
  output logic                          load_ok,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rald_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser
);
  import rald_pkg::*;

  assign load_ok = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_ok) begin
      m_axis_tvalid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && step && res.valid) begin
      m_axis_tdata <= {{(M_TDATA_W - OUT_ADDR_W - LEN_W){1'b0}},
                       res.result.list_length, res.result.address};
      m_axis_tlast <= res.result.address_is_last;
      m_axis_tuser <= res.result.group_error;
    end
  end

endmodule

@@ tb/tb_relay_address_list_decompressor.sv @@
`timescale 1ns / 1ps

module tb_relay_address_list_decompressor;
  import rald_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1750;

  typedef struct {
    item_t fields;
    bit    hold;
  } list_byte_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_SPARSE_DROPS,
    RX_EVERY_FIFTH,
    RX_COIN
  } rx_mode_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;

  list_byte_t byte_queue[$];
  result_t    addr_expected[$];
  list_byte_t on_bus;
  int         burst_left = 1;
  int         gap_left = 0;
  int         n_errors = 0;
  int         cycle_count = 0;
  logic [11:0] rx_phase = '0;

  logic [ADDR_W-1:0] prev_address = '0;
  logic [6:0]        group_held[ADDRESS_BYTES];
  int                group_fill = 0;
  int                header_seen = 0;
  int                groups_left = 0;
  logic [LEN_W-1:0]  consumed = '0;
  bit                list_open = 1'b0;

  relay_address_list_decompressor u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic decode_list_byte(input item_t it);
    logic [ADDR_W-1:0] delta;
    result_t r;
    if (it.list_start) begin
      prev_address = '0;
      group_fill = 0;
      header_seen = 0;
      groups_left = it.relay_count + 1;
      consumed = '0;
      list_open = 1'b1;
    end else if (!list_open) begin
      return;
    end
    consumed = consumed + 1'b1;
    r = '0;
    if (header_seen < ADDRESS_BYTES) begin
      prev_address = {prev_address[ADDR_W-9:0], it.data_byte};
      header_seen++;
      if (header_seen == ADDRESS_BYTES) begin
        r.address = prev_address[OUT_ADDR_W-1:0];
        addr_expected.push_back(r);
      end
      return;
    end
    if (group_fill >= ADDRESS_BYTES) begin
      group_fill = 0;
      list_open = 1'b0;
      r.group_error = 1'b1;
      addr_expected.push_back(r);
      return;
    end
    group_held[group_fill] = it.data_byte[7:1];
    group_fill++;
    if (!it.data_byte[0]) return;
    delta = '0;
    for (int i = 0; i < group_fill; i++) delta = {delta[ADDR_W-9:0], 1'b0, group_held[i]};
    prev_address = prev_address ^ delta;
    group_fill = 0;
    if (groups_left > 0) groups_left--;
    r.address = prev_address[OUT_ADDR_W-1:0];
    if (groups_left == 0) begin
      list_open = 1'b0;
      r.address_is_last = 1'b1;
      r.list_length = consumed;
    end
    addr_expected.push_back(r);
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic start, input logic [3:0] relays);
    list_byte_t b;
    b.fields.data_byte = data;
    b.fields.list_start = start;
    b.fields.relay_count = relays;
    b.hold = 1'b0;
    byte_queue.push_back(b);
  endtask

  // well-formed lists mostly; some carry an overlong group or are cut short by a restart
  task automatic queue_random_list(inout int n_queued, input bit hold_first);
    list_byte_t seq[$];
    list_byte_t b;
    int relays;
    int shape;
    int bad_group;
    int glen;
    relays = $urandom_range(0, 15);
    shape = $urandom_range(0, 9);
    bad_group = (shape == 0) ? $urandom_range(0, relays) : -1;
    b.hold = 1'b0;
    for (int i = 0; i < ADDRESS_BYTES; i++) begin
      b.fields.data_byte = 8'($urandom_range(0, 255));
      b.fields.list_start = (i == 0);
      b.fields.relay_count = (i == 0) ? 4'(relays) : 4'($urandom_range(0, 15));
      seq.push_back(b);
    end
    for (int g = 0; g <= relays; g++) begin
      glen = (g == bad_group) ? ADDRESS_BYTES + 1 : $urandom_range(1, ADDRESS_BYTES);
      for (int k = 0; k < glen; k++) begin
        b.fields.data_byte = {7'($urandom_range(0, 127)),
                              k == glen - 1 && (g != bad_group || $urandom_range(0, 1) == 1)};
        b.fields.list_start = 1'b0;
        b.fields.relay_count = 4'($urandom_range(0, 15));
        seq.push_back(b);
      end
      if (g == bad_group) break;
    end
    if (shape == 1) seq = seq[0:$urandom_range(0, seq.size() - 2)];
    seq[0].hold = hold_first;
    foreach (seq[i]) byte_queue.push_back(seq[i]);
    n_queued += seq.size();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3))
        queue_byte(8'($urandom_range(0, 255)), 1'b0, 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_list_byte(on_bus.fields);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_queue.size() == 0 ||
                     (byte_queue[0].hold && addr_expected.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          on_bus = byte_queue.pop_front();
          s_axis_tdata <= {{(S_TDATA_W - BYTE_W - RELAY_W){1'b0}},
                           on_bus.fields.relay_count, on_bus.fields.data_byte};
          s_axis_tuser <= on_bus.fields.list_start;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : addr_monitor
    result_t want;
    rx_mode_e mode;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (addr_expected.size() == 0) begin
          $display("%0t: unexpected address transfer, expected none, actual %h last %b err %b",
                   $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          n_errors++;
        end else begin
          want = addr_expected.pop_front();
          check_field("address", want.address, m_axis_tdata[OUT_ADDR_W-1:0]);
          check_field("list_length", want.list_length,
                      m_axis_tdata[OUT_ADDR_W +: LEN_W]);
          check_field("address_is_last", want.address_is_last, m_axis_tlast);
          check_field("group_error", want.group_error, m_axis_tuser);
        end
      end
      rx_phase <= rx_phase + 1'b1;
      mode = rx_mode_e'(rx_phase[10:9]);
      case (mode)
        RX_OPEN:         m_axis_tready <= 1'b1;
        RX_SPARSE_DROPS: m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_EVERY_FIFTH:  m_axis_tready <= (rx_phase % 5 == 0);
        default:         m_axis_tready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int n_random;
    int n_lists;
    n_random = 0;
    n_lists = 0;

    queue_byte(8'h55, 1'b0, 4'h3);
    queue_byte(8'hFF, 1'b1, 4'hF);
    queue_byte(8'h00, 1'b0, 4'hA);
    queue_byte(8'hFF, 1'b0, 4'h0);
    queue_byte(8'h00, 1'b0, 4'hF);
    queue_byte(8'hFF, 1'b0, 4'h0);
    queue_byte(8'h00, 1'b0, 4'h5);
    queue_byte(8'h01, 1'b0, 4'h0);
    // restart in mid list, then a group that runs past six bytes
    queue_byte(8'h80, 1'b1, 4'h5);
    queue_byte(8'h7F, 1'b0, 4'h0);
    queue_byte(8'h01, 1'b0, 4'h0);
    queue_byte(8'hFE, 1'b0, 4'h0);
    queue_byte(8'hAA, 1'b0, 4'h0);
    queue_byte(8'h55, 1'b0, 4'h0);
    repeat (ADDRESS_BYTES + 1) queue_byte(8'hFE, 1'b0, 4'h0);
    queue_byte(8'hFF, 1'b0, 4'h0);
    queue_byte(8'h12, 1'b1, 4'h0);
    queue_byte(8'h34, 1'b0, 4'hF);
    queue_byte(8'h56, 1'b0, 4'h0);
    queue_byte(8'h78, 1'b0, 4'h0);
    queue_byte(8'h9A, 1'b0, 4'h0);
    queue_byte(8'hBC, 1'b0, 4'h0);
    queue_byte(8'hFF, 1'b0, 4'h0);

    while (n_random < RANDOM_BYTES) begin
      queue_random_list(n_random, n_lists % 25 == 0);
      n_lists++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (addr_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
